// File: design/icfx_pkg.sv
// Shared types and constants for the ICMP checksum address fixup unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package icfx_pkg;

  // Longest packet tracked; byte position saturates here.
  localparam int MAX_PACKET_BYTES = 65535;
  localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 1);
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_PACKET_BYTES);

  // Header field checks.
  localparam logic [3:0]  IP_VERSION_4   = 4'd4;
  localparam logic [3:0]  MIN_HDR_WORDS  = 4'd5;
  localparam logic [15:0] FRAG_LIMIT     = 16'h2000;
  localparam logic [15:0] SUM_GOOD       = 16'hFFFF;
  localparam logic [7:0]  PROTO_ICMP     = 8'd1;
  localparam logic [7:0]  ICMP_ECHO_REPLY = 8'd0;

  // Fixed header byte offsets.
  localparam logic [POS_W-1:0] POS_TLEN_HI = POS_W'(2);
  localparam logic [POS_W-1:0] POS_TLEN_LO = POS_W'(3);
  localparam logic [POS_W-1:0] POS_FRAG_HI = POS_W'(6);
  localparam logic [POS_W-1:0] POS_FRAG_LO = POS_W'(7);
  localparam logic [POS_W-1:0] POS_PROTO   = POS_W'(9);

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam logic [QCNT_W-1:0] DEPTH_CNT = QCNT_W'(QUEUE_DEPTH);

  // One queued job: one output byte, or a pair (checksum bytes).
  typedef struct packed {
    logic        pair;     // two output bytes
    logic        rw;       // pair carries a rewritten checksum
    logic        last;     // end of packet on the final byte of the job
    logic [7:0]  byte_a;   // single byte, or first of a pair
    logic [7:0]  byte_b;   // second of a pair
    logic [31:0] sum;      // unfolded new checksum
  } entry_t;

endpackage

// File: design/icfx_if.sv
// Valid/ready stream channels for packet bytes in and result bytes out.
// Depends on nothing.
`timescale 1ns / 1ps

interface icfx_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [15:0] frame_length;
  logic        last_byte;

  modport source (output valid, data_byte, frame_length, last_byte, input ready);
  modport sink   (input valid, data_byte, frame_length, last_byte, output ready);
endinterface

interface icfx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       rewritten;
  logic       out_last;

  modport source (output valid, out_byte, rewritten, out_last, input ready);
  modport sink   (input valid, out_byte, rewritten, out_last, output ready);
endinterface

// File: design/icmp_checksum_address_fixup_unit.sv
// Top level of the ICMP checksum address fixup unit: config registers and wiring.
// Depends on icfx_pkg, icfx_if, icfx_queue, icfx_front and icfx_back.
//
//   channel   dir  handshake         payload
//   pkt       in   valid/ready       data_byte[7:0], frame_length[15:0], last_byte
//   res       out  valid/ready       out_byte[7:0], rewritten, out_last
//   apb       in   psel/penable      paddr[2:0], pwdata[31:0], prdata[31:0], pready=1
//
// Sustained rate is one byte per cycle in and out while neither side stalls.
// Front parses one byte per cycle unless the queue is full; the back shows one
// byte per cycle from its output register while res.ready allows, so a checksum
// pair (two bytes) follows a held byte that gave nothing. res.valid rises once
// the queue entry written at the accepting edge reaches the output register.
// The 4-entry queue lets input and output stall independently.
// Synchronous active-high reset clears all control state; no clearing pass.
`timescale 1ns / 1ps

module icmp_checksum_address_fixup_unit (
  input  logic        clk,
  input  logic        rst,
  icfx_in_if.sink     pkt,
  icfx_out_if.source  res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import icfx_pkg::*;

  localparam logic REG_INNER = 1'b0;
  localparam logic REG_OUTER = 1'b1;

  logic [31:0] inner_address;
  logic [31:0] outer_address;
  logic [31:0] addr_delta;     // 2*(inner halves) - 2*(outer halves), mod 2^32
  logic        cfg_wr;

  entry_t push_entry;
  entry_t head_entry;
  logic   push;
  logic   pop;
  logic   queue_full;
  logic   queue_empty;

  function automatic logic [31:0] calc_delta(input logic [31:0] inn,
                                             input logic [31:0] outr);
    logic [31:0] d;
    d = {16'b0, inn[31:16]} + {16'b0, inn[15:0]}
      - {16'b0, outr[31:16]} - {16'b0, outr[15:0]};
    return {d[30:0], 1'b0};
  endfunction

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // the delta is refreshed on every write so the data path needs one add
  always_ff @(posedge clk) begin
    if (rst) begin
      inner_address <= '0;
      outer_address <= '0;
      addr_delta    <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_INNER: begin
          inner_address <= pwdata;
          addr_delta    <= calc_delta(pwdata, outer_address);
        end
        REG_OUTER: begin
          outer_address <= pwdata;
          addr_delta    <= calc_delta(inner_address, pwdata);
        end
        default: begin
          addr_delta <= addr_delta;
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_INNER: prdata = inner_address;
      REG_OUTER: prdata = outer_address;
      default:   prdata = '0;
    endcase
  end

  icfx_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pkt        (pkt),
    .addr_delta (addr_delta),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  icfx_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_entry (head_entry),
    .empty      (queue_empty)
  );

  icfx_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_entry  (head_entry),
    .queue_empty (queue_empty),
    .pop         (pop),
    .res         (res)
  );

endmodule

// File: design/icfx_queue.sv
// Small job queue between the front (parser) and the back (emitter).
// Depends on icfx_pkg.
`timescale 1ns / 1ps

module icfx_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  icfx_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output icfx_pkg::entry_t head_entry,
  output logic            empty
);
  import icfx_pkg::*;

  entry_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   head_ptr;
  logic [QPTR_W-1:0]   tail_ptr;
  logic [QCNT_W-1:0]   count;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] ptr);
    if (ptr == QPTR_W'(QUEUE_DEPTH - 1)) return '0;
    return ptr + QPTR_W'(1);
  endfunction

  assign full       = (count == DEPTH_CNT);
  assign empty      = (count == '0);
  assign head_entry = slots[head_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr <= '0;
      tail_ptr <= '0;
      count    <= '0;
    end else begin
      if (push) tail_ptr <= ptr_inc(tail_ptr);
      if (pop)  head_ptr <= ptr_inc(head_ptr);
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= DEPTH_CNT)
    else $error("queue count above depth");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("pop from empty queue");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
      (push && !pop) |=> count == $past(count) + QCNT_W'(1))
    else $error("push lost");
`endif

endmodule

// File: design/icfx_front.sv
// Front end: accepts packet bytes, tracks IPv4/ICMP header fields and queues jobs.
// Depends on icfx_pkg and icfx_if.
`timescale 1ns / 1ps

module icfx_front (
  input  logic             clk,
  input  logic             rst,
  icfx_in_if.sink          pkt,
  input  logic [31:0]      addr_delta,
  input  logic             queue_full,
  output logic             push,
  output icfx_pkg::entry_t push_entry
);
  import icfx_pkg::*;

  logic [POS_W-1:0] byte_position;
  logic [3:0]       header_words;
  logic             version_ok;
  logic [15:0]      fragment_word;
  logic [15:0]      total_length;
  logic [7:0]       protocol_byte;
  logic [15:0]      header_sum;
  logic [7:0]       high_byte_pending;
  logic [7:0]       msg_type_byte;

  logic             accept;
  logic             first_byte;
  logic [3:0]       hw_cur;
  logic [POS_W-1:0] hlen;
  logic             hdr_ok;
  logic             in_hdr;
  logic             at_hi;
  logic             at_lo;
  logic             csum_ok;
  logic [16:0]      sum_raw;
  logic [15:0]      sum_next;

  assign pkt.ready  = !queue_full;
  assign accept     = pkt.valid && !queue_full;
  assign first_byte = (byte_position == '0);
  assign hw_cur     = first_byte ? pkt.data_byte[3:0] : header_words;
  assign hlen       = POS_W'({hw_cur, 2'b00});
  assign hdr_ok     = (hw_cur >= MIN_HDR_WORDS);
  assign in_hdr     = (byte_position < hlen);
  assign at_hi      = hdr_ok && (byte_position == hlen + POS_W'(2));
  assign at_lo      = hdr_ok && (byte_position == hlen + POS_W'(3));

  // running ones'-complement header sum, big-endian word order
  always_comb begin
    if (byte_position[0]) sum_raw = {1'b0, header_sum} + {9'b0, pkt.data_byte};
    else                  sum_raw = {1'b0, header_sum} + {1'b0, pkt.data_byte, 8'b0};
    sum_next = sum_raw[15:0] + {15'b0, sum_raw[16]};
  end

  assign csum_ok = version_ok && (fragment_word < FRAG_LIMIT) &&
                   (pkt.frame_length >= total_length) &&
                   (pkt.frame_length >= 16'(hlen)) &&
                   (header_sum == SUM_GOOD) && (protocol_byte == PROTO_ICMP) &&
                   (msg_type_byte != ICMP_ECHO_REPLY);

  // held checksum high byte emits nothing unless it ends the packet
  assign push = accept && !(at_hi && !pkt.last_byte);

  always_comb begin
    push_entry.pair   = at_lo;
    push_entry.rw     = at_lo && csum_ok;
    push_entry.last   = pkt.last_byte;
    push_entry.byte_a = at_lo ? high_byte_pending : pkt.data_byte;
    push_entry.byte_b = pkt.data_byte;
    push_entry.sum    = {16'b0, high_byte_pending, pkt.data_byte} + addr_delta;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      header_words      <= '0;
      version_ok        <= 1'b0;
      fragment_word     <= '0;
      total_length      <= '0;
      protocol_byte     <= '0;
      header_sum        <= '0;
      high_byte_pending <= '0;
      msg_type_byte     <= '0;
    end else if (accept) begin
      if (pkt.last_byte) begin
        byte_position     <= '0;
        header_words      <= '0;
        version_ok        <= 1'b0;
        fragment_word     <= '0;
        total_length      <= '0;
        protocol_byte     <= '0;
        header_sum        <= '0;
        high_byte_pending <= '0;
        msg_type_byte     <= '0;
      end else begin
        if (first_byte) begin
          version_ok   <= (pkt.data_byte[7:4] == IP_VERSION_4);
          header_words <= pkt.data_byte[3:0];
        end
        if (in_hdr) header_sum <= sum_next;
        if (byte_position == POS_TLEN_HI) total_length[15:8]  <= pkt.data_byte;
        if (byte_position == POS_TLEN_LO) total_length[7:0]   <= pkt.data_byte;
        if (byte_position == POS_FRAG_HI) fragment_word[15:8] <= pkt.data_byte;
        if (byte_position == POS_FRAG_LO) fragment_word[7:0]  <= pkt.data_byte;
        if (byte_position == POS_PROTO)   protocol_byte       <= pkt.data_byte;
        if (hdr_ok && byte_position == hlen) msg_type_byte <= pkt.data_byte;
        if (at_hi) high_byte_pending <= pkt.data_byte;
        if (byte_position != MAX_POS) byte_position <= byte_position + POS_W'(1);
      end
    end
  end

endmodule

// File: design/icfx_back.sv
// Back end: pops queued jobs, folds the new checksum, drives the output register.
// Depends on icfx_pkg and icfx_if.
`timescale 1ns / 1ps

module icfx_back (
  input  logic             clk,
  input  logic             rst,
  input  icfx_pkg::entry_t head_entry,
  input  logic             queue_empty,
  output logic             pop,
  icfx_out_if.source       res
);
  import icfx_pkg::*;

  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_rw;
  logic        out_last;
  logic        phase;        // second byte of a pair still owed
  logic [7:0]  saved_byte;
  logic        saved_rw;
  logic        saved_last;

  logic        load;
  logic [31:0] fold1;
  logic [31:0] fold2;
  logic [7:0]  first_b;
  logic [7:0]  second_b;

  // upper half taken as signed
  function automatic logic [31:0] fold_signed(input logic [31:0] s);
    return {16'b0, s[15:0]} + {{16{s[31]}}, s[31:16]};
  endfunction

  assign fold1    = fold_signed(head_entry.sum);
  assign fold2    = fold_signed(fold1);
  assign first_b  = head_entry.rw ? fold2[15:8] : head_entry.byte_a;
  assign second_b = head_entry.rw ? fold2[7:0]  : head_entry.byte_b;

  assign load = !out_valid || res.ready;
  assign pop  = load && !phase && !queue_empty;

  assign res.valid     = out_valid;
  assign res.out_byte  = out_byte;
  assign res.rewritten = out_rw;
  assign res.out_last  = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (load) begin
      if (phase) begin
        out_valid <= 1'b1;
        phase     <= 1'b0;
      end else begin
        out_valid <= !queue_empty;
        phase     <= !queue_empty && head_entry.pair;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (phase) begin
        out_byte <= saved_byte;
        out_rw   <= saved_rw;
        out_last <= saved_last;
      end else if (!queue_empty) begin
        if (head_entry.pair) begin
          out_byte   <= first_b;
          out_rw     <= head_entry.rw;
          out_last   <= 1'b0;
          saved_byte <= second_b;
          saved_rw   <= head_entry.rw;
          saved_last <= head_entry.last;
        end else begin
          out_byte <= head_entry.byte_a;
          out_rw   <= 1'b0;
          out_last <= head_entry.last;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_phase_valid: assert property (@(posedge clk) disable iff (rst) phase |-> out_valid)
    else $error("pair second byte owed without first shown");
  a_pair_phase: assert property (@(posedge clk) disable iff (rst)
      (pop && head_entry.pair) |=> phase && !out_last)
    else $error("pair pop did not arm second byte");
  a_no_pop_in_pair: assert property (@(posedge clk) disable iff (rst) phase |-> !pop)
    else $error("queue popped while pair in flight");
`endif

endmodule
